### rtl/sh24_pkg.sv
package sh24_pkg;

   // siphash initialization constants
   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

   localparam logic [63:0] KEY_LOW_RESET  = 64'd31313;
   localparam logic [63:0] KEY_HIGH_RESET = 64'd1313131;
   localparam logic [63:0] FINAL_XOR      = 64'h00000000000000ff;

   localparam int FIN_ROUNDS  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the csr port
   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   typedef enum logic [1:0] {
      OP_ABSORB,
      OP_FINAL_FULL,
      OP_FINAL_PART
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] data;
      logic [2:0]  count;
   } entry_type;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } sip_state_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
      rotl64 = (x << r) | (x >> (64 - r));
   endfunction

   function automatic sip_state_type sip_round(input sip_state_type s);
      sip_state_type t;
      t = s;
      t.v0 = t.v0 + t.v1;
      t.v1 = rotl64(t.v1, 13) ^ t.v0;
      t.v0 = rotl64(t.v0, 32);
      t.v2 = t.v2 + t.v3;
      t.v3 = rotl64(t.v3, 16) ^ t.v2;
      t.v0 = t.v0 + t.v3;
      t.v3 = rotl64(t.v3, 21) ^ t.v0;
      t.v2 = t.v2 + t.v1;
      t.v1 = rotl64(t.v1, 17) ^ t.v2;
      t.v2 = rotl64(t.v2, 32);
      return t;
   endfunction

   function automatic sip_state_type sip_init(input logic [63:0] k0,
                                              input logic [63:0] k1);
      sip_state_type t;
      t.v0 = SIP_C0 ^ k0;
      t.v1 = SIP_C1 ^ k1;
      t.v2 = SIP_C2 ^ k0;
      t.v3 = SIP_C3 ^ k1;
      return t;
   endfunction

endpackage

### rtl/sh24_front.sv
module sh24_front
   import sh24_pkg::*;
(
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_word_data,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   logic [63:0] tail;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      // keep only the valid bytes of a short last word
      for (int i = 0; i < 8; i++) begin
         tail[8*i +: 8] = (req_byte_count > 4'(i)) ? req_word_data[8*i +: 8] : 8'h00;
      end

      push_entry.count = req_byte_count[2:0];
      if (!req_last_word) begin
         push_entry.op   = OP_ABSORB;
         push_entry.data = req_word_data;
      end else if (req_byte_count >= 4'd8) begin
         push_entry.op   = OP_FINAL_FULL;
         push_entry.data = req_word_data;
      end else begin
         push_entry.op   = OP_FINAL_PART;
         push_entry.data = tail;
      end
   end

endmodule

### rtl/sh24_queue.sv
module sh24_queue
   import sh24_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty,
   output logic      full
);

   entry_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_queue_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= QCNT_W'(QUEUE_DEPTH)) && !(push && full && !pop))
      else $error("queue overrun");
`endif

endmodule

### rtl/sh24_back.sv
module sh24_back
   import sh24_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  entry_type   pop_entry,
   output logic        pop,
   input  logic        reload,
   input  logic [63:0] key_low,
   input  logic [63:0] key_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_R1,
      ST_R2,
      ST_FIN,
      ST_OUT
   } state_type;

   state_type     st_ff, st_in;
   sip_state_type v_ff, v_in;
   sip_state_type round_arg;
   sip_state_type round_out;
   logic [7:0]    len_ff, len_in;
   logic [63:0]   m_ff, m_in;
   logic          need_block_ff, need_block_in;
   logic          final_ff, final_in;
   logic [1:0]    fin_cnt_ff, fin_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   hash_ff, hash_in;
   logic [7:0]    len_sum;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   always_comb begin
      st_in         = st_ff;
      v_in          = v_ff;
      len_in        = len_ff;
      m_in          = m_ff;
      need_block_in = need_block_ff;
      final_in      = final_ff;
      fin_cnt_in    = fin_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      hash_in       = hash_ff;
      pop           = 1'b0;
      len_sum       = len_ff + {5'b00000, pop_entry.count};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // message word for a new entry
      if (st_ff == ST_IDLE && pop_valid) begin
         pop = 1'b1;
         case (pop_entry.op)
            OP_ABSORB, OP_FINAL_FULL: begin
               m_in          = pop_entry.data;
               len_in        = len_ff + 8'd8;
               need_block_in = (pop_entry.op == OP_FINAL_FULL);
               final_in      = 1'b0;
            end
            OP_FINAL_PART: begin
               m_in          = {len_sum, pop_entry.data[55:0]};
               len_in        = len_sum;
               need_block_in = 1'b0;
               final_in      = 1'b1;
            end
            default: begin
               m_in          = pop_entry.data;
               len_in        = len_ff + 8'd8;
               need_block_in = 1'b0;
               final_in      = 1'b0;
            end
         endcase
      end

      // one shared round unit
      round_arg = v_ff;
      if (pop) begin
         round_arg.v3 = v_ff.v3 ^ m_in;
      end
      round_out = sip_round(round_arg);

      case (st_ff)
         ST_IDLE: begin
            if (pop) begin
               v_in  = round_out;
               st_in = ST_R2;
            end
         end
         ST_R1: begin
            v_in  = round_out;
            st_in = ST_R2;
         end
         ST_R2: begin
            v_in    = round_out;
            v_in.v0 = round_out.v0 ^ m_ff;
            if (need_block_ff) begin
               // full last word done, now the length-only block
               m_in          = {len_ff, 56'h0};
               v_in.v3       = round_out.v3 ^ {len_ff, 56'h0};
               need_block_in = 1'b0;
               final_in      = 1'b1;
               st_in         = ST_R1;
            end else if (final_ff) begin
               v_in.v2    = round_out.v2 ^ FINAL_XOR;
               fin_cnt_in = '0;
               st_in      = ST_FIN;
            end else begin
               st_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            v_in       = round_out;
            fin_cnt_in = fin_cnt_ff + 1'b1;
            if (fin_cnt_ff == 2'(FIN_ROUNDS - 1)) begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               hash_in      = v_ff.v0 ^ v_ff.v1 ^ v_ff.v2 ^ v_ff.v3;
               rsp_valid_in = 1'b1;
               v_in         = sip_init(key_low, key_high);
               len_in       = 8'd0;
               final_in     = 1'b0;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // key write restarts the message
      if (reload) begin
         v_in          = sip_init(key_low, key_high);
         len_in        = 8'd0;
         need_block_in = 1'b0;
         final_in      = 1'b0;
         st_in         = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         v_ff          <= sip_init(KEY_LOW_RESET, KEY_HIGH_RESET);
         len_ff        <= 8'd0;
         need_block_ff <= 1'b0;
         final_ff      <= 1'b0;
         fin_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         v_ff          <= v_in;
         len_ff        <= len_in;
         need_block_ff <= need_block_in;
         final_ff      <= final_in;
         fin_cnt_ff    <= fin_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      m_ff    <= m_in;
      hash_ff <= hash_in;
   end

`ifndef SYNTH
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (st_ff == ST_IDLE) && pop_valid)
      else $error("entry taken outside idle");

   a_fin_to_out: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FIN) && (fin_cnt_ff == 2'(FIN_ROUNDS - 1)) && !reload
      |=> (st_ff == ST_OUT))
      else $error("finalization round count wrong");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_OUT))
      else $error("result loaded outside output state");
`endif

endmodule

### rtl/siphash_2_4_word_stream_core.sv
// channel | direction | ports                                   | handshake
// req     | in        | req_word_data, req_byte_count,          | req_valid / req_stall
//         |           | req_last_word                           |
// rsp     | out       | rsp_hash_value                          | rsp_valid / rsp_stall
// csr     | in/out    | csr_paddr[3:0] (key_low 0, key_high 8)  | apb, csr_pready tied high
//
// a full word gets 2 siphash rounds in the round engine, one siphash round per cycle
// a short last word goes through 2 rounds, 4 finalization rounds and the output load,
// a last word with 8 bytes gets one more 2-round block for the length
// a word is registered in the 2-entry queue before the engine can take it
// synchronous reset loads the key defaults and the derived state, no clearing pass
// req_stall rises only when the queue is full; a finished hash goes straight to the
// output register, the engine waits only when a second hash is ready while rsp_stall holds
module siphash_2_4_word_stream_core
   import sh24_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // word input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_word_data,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   // hash output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   // key registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic        reload_ff, reload_in;
   logic        csr_write;

   logic        push;
   entry_type   push_entry;
   logic        pop;
   entry_type   pop_entry;
   logic        queue_empty;
   logic        queue_full;

   // register select is address bit 3, low address bits alias
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_KEY_HIGH) ? key_high_ff : key_low_ff;

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      reload_in   = csr_write;
      if (csr_write) begin
         case (csr_paddr[3])
            REG_KEY_LOW:  key_low_in  = csr_pwdata;
            REG_KEY_HIGH: key_high_in = csr_pwdata;
            default:      key_low_in  = key_low_ff;
         endcase
      end
   end

   // key write sets reload_ff, which makes the back end reload the engine state from the new keys
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KEY_LOW_RESET;
         key_high_ff <= KEY_HIGH_RESET;
         reload_ff   <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         reload_ff   <= reload_in;
      end
   end

   // front: classify and mask the incoming word
   sh24_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word_data  (req_word_data),
      .req_byte_count (req_byte_count),
      .req_last_word  (req_last_word),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   // short queue between front and round engine
   sh24_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // back: round engine, finalization and result register
   sh24_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (!queue_empty),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .reload         (reload_ff),
      .key_low        (key_low_ff),
      .key_high       (key_high_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
